// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is asserted.
`define ASSERT_DIS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_DIS(label, clk, rst_n, !(cond), msg)

`endif

// ----- src/ysr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the 4:2:0 scaler and color converter.
package ysr_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;

  localparam int unsigned SRC_W = 10;
  localparam int unsigned POS_W = 12;
  localparam int unsigned SCR_W = 13;
  localparam int unsigned PROD_W = POS_W + SRC_W;

  localparam logic [SRC_W-1:0] RST_SRC_W  = 10'd512;
  localparam logic [SRC_W-1:0] RST_SRC_H  = 10'd512;
  localparam logic [POS_W-1:0] RST_SURF_W = 12'd800;
  localparam logic [POS_W-1:0] RST_SURF_H = 12'd600;

  typedef enum logic [1:0] {
    MODE_LUMA   = 2'd0,
    MODE_BLUE   = 2'd1,
    MODE_RED    = 2'd2,
    MODE_RENDER = 2'd3
  } ysr_mode_e;

  typedef enum logic [2:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_DISP_X = 3'd2,
    CFG_DISP_Y = 3'd3,
    CFG_DISP_W = 3'd4,
    CFG_DISP_H = 3'd5,
    CFG_SURF_W = 3'd6,
    CFG_SURF_H = 3'd7
  } ysr_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRODUCT,
    ST_DIVIDE,
    ST_ADDR,
    ST_MULT,
    ST_SUM,
    ST_EMIT
  } ysr_state_e;

  typedef struct packed {
    logic       luma_en;
    logic       blue_en;
    logic       red_en;
    logic [8:0] row;
    logic [8:0] col;
    logic [7:0] sample;
  } ysr_wr_req_t;

  typedef struct packed {
    logic stage1;
    logic stage2;
  } ysr_conv_ctl_t;

endpackage

// ----- src/ysr_frame_store.sv -----
`timescale 1ns / 1ps
// Luma and chroma plane memories with one write port and one registered read port.
module ysr_frame_store #(
  parameter int unsigned MAX_WIDTH  = ysr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ysr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  ysr_pkg::ysr_wr_req_t               wr_req_i,
  input  logic                               rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]      rd_row_i,
  output logic [7:0]                         luma_o,
  output logic [7:0]                         blue_o,
  output logic [7:0]                         red_o
);
  import ysr_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned CXW = XW - 1;
  localparam int unsigned CYW = YW - 1;
  localparam int unsigned CHROMA_W = (MAX_WIDTH + 1) / 2;
  localparam int unsigned CHROMA_H = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned LUMA_DEPTH   = 2 ** (XW + YW);
  localparam int unsigned CHROMA_DEPTH = 2 ** (CXW + CYW);

  logic [7:0]  luma_mem   [LUMA_DEPTH];
  logic [15:0] chroma_mem [CHROMA_DEPTH];

  logic                 luma_in_range;
  logic                 chroma_in_range;
  logic [XW+YW-1:0]     luma_waddr;
  logic [CXW+CYW-1:0]   chroma_waddr;
  logic [XW+YW-1:0]     luma_raddr;
  logic [CXW+CYW-1:0]   chroma_raddr;
  logic [7:0]           luma_q;
  logic [15:0]          chroma_q;

  assign luma_in_range   = (32'(wr_req_i.row) < MAX_HEIGHT) && (32'(wr_req_i.col) < MAX_WIDTH);
  assign chroma_in_range = (32'(wr_req_i.row) < CHROMA_H) && (32'(wr_req_i.col) < CHROMA_W);
  assign luma_waddr      = {YW'(wr_req_i.row), XW'(wr_req_i.col)};
  assign chroma_waddr    = {CYW'(wr_req_i.row), CXW'(wr_req_i.col)};
  assign luma_raddr      = {rd_row_i, rd_col_i};
  assign chroma_raddr    = {rd_row_i[YW-1:1], rd_col_i[XW-1:1]};

  always_ff @(posedge clk_i) begin
    if (wr_req_i.luma_en && luma_in_range) begin
      luma_mem[luma_waddr] <= wr_req_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_req_i.blue_en && chroma_in_range) begin
      chroma_mem[chroma_waddr][7:0] <= wr_req_i.sample;
    end
    if (wr_req_i.red_en && chroma_in_range) begin
      chroma_mem[chroma_waddr][15:8] <= wr_req_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      luma_q   <= luma_mem[luma_raddr];
      chroma_q <= chroma_mem[chroma_raddr];
    end
  end

  assign luma_o = luma_q;
  assign blue_o = chroma_q[7:0];
  assign red_o  = chroma_q[15:8];

endmodule

// ----- src/ysr_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider producing one quotient bit per cycle for the scale mapping.
module ysr_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ysr_pkg::PROD_W-1:0]  dividend_i,
  input  logic [ysr_pkg::POS_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [ysr_pkg::SRC_W-1:0]   quotient_o
);
  import ysr_pkg::*;

  localparam int unsigned CNT_W = $clog2(SRC_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] rem_q, rem_d;
  logic [SRC_W-1:0] quo_q, quo_d;
  logic [POS_W-1:0] div_q, div_d;
  logic [POS_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q, quo_q[SRC_W-1]};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    if (start_i) begin
      cnt_d = CNT_W'(SRC_W);
      rem_d = dividend_i[PROD_W-1:SRC_W];
      quo_d = dividend_i[SRC_W-1:0];
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = ge ? POS_W'(shifted - {1'b0, div_q}) : shifted[POS_W-1:0];
      quo_d = {quo_q[SRC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ----- src/ysr_color_conv.sv -----
`timescale 1ns / 1ps
// Two-stage full-range BT.601 YCbCr to RGB converter with clamping.
module ysr_color_conv (
  input  logic                   clk_i,
  input  ysr_pkg::ysr_conv_ctl_t ctl_i,
  input  logic [7:0]             luma_i,
  input  logic [7:0]             blue_i,
  input  logic [7:0]             red_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);
  import ysr_pkg::*;

  localparam logic signed [17:0] K_R_CR = 18'sd359;
  localparam logic signed [17:0] K_G_CB = 18'sd88;
  localparam logic signed [17:0] K_G_CR = 18'sd183;
  localparam logic signed [17:0] K_B_CB = 18'sd454;
  localparam logic signed [17:0] K_RND  = 18'sd128;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v[10]) begin
      res = 8'd0;
    end else if (v[9:8] != 2'b00) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic signed [7:0]  cb;
  logic signed [7:0]  cr;
  logic signed [17:0] p_r_q, p_gb_q, p_gr_q, p_b_q;
  logic [7:0]         y_q;
  logic signed [17:0] t_r, t_g, t_b;
  logic signed [10:0] y_ext;
  logic signed [10:0] sum_r, sum_g, sum_b;
  logic [7:0]         red_q, green_q, blue_q;

  assign cb = $signed({~blue_i[7], blue_i[6:0]});
  assign cr = $signed({~red_i[7], red_i[6:0]});

  always_ff @(posedge clk_i) begin
    if (ctl_i.stage1) begin
      p_r_q  <= 18'(cr) * K_R_CR;
      p_gb_q <= 18'(cb) * K_G_CB;
      p_gr_q <= 18'(cr) * K_G_CR;
      p_b_q  <= 18'(cb) * K_B_CB;
      y_q    <= luma_i;
    end
  end

  assign t_r   = p_r_q + K_RND;
  assign t_g   = p_gb_q + p_gr_q + K_RND;
  assign t_b   = p_b_q + K_RND;
  assign y_ext = $signed({3'b000, y_q});
  assign sum_r = y_ext + 11'($signed(t_r[17:8]));
  assign sum_g = y_ext - 11'($signed(t_g[17:8]));
  assign sum_b = y_ext + 11'($signed(t_b[17:8]));

  always_ff @(posedge clk_i) begin
    if (ctl_i.stage2) begin
      red_q   <= clamp_byte(sum_r);
      green_q <= clamp_byte(sum_g);
      blue_q  <= clamp_byte(sum_b);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ----- src/yuv420_scale_to_rgb_unit.sv -----
`timescale 1ns / 1ps
// Top level: planar 4:2:0 frame store, nearest-neighbor scaler and RGB converter.
// Load transfers (luma, blue chroma, red chroma) write one sample into the plane
// memories and leave the unit ready. A render transfer maps the current display
// position to the source picture as floor(pos * source / display), clamped into
// the source and planes, reads luma and chroma there, converts to RGB and advances
// in raster order. A render transfer with an empty display rectangle, or whose
// pixel is off the surface and is not the last of the frame, leaves the unit
// ready and yields nothing. The clipped last position still yields its marker.
// A visible pixel runs the product, divide, address, multiply, sum and emit
// states; divide waits on the two shared-step restoring dividers, one quotient
// bit per cycle, and emit on a result still held in the output register.
// The plane memories are not cleared; render only positions that were loaded.
`include "assert_macros.svh"
module yuv420_scale_to_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = ysr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ysr_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  sample_i,
  input  logic [8:0]  sample_row_i,
  input  logic [8:0]  sample_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] screen_x_o,
  output logic [12:0] screen_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        pixel_valid_o,
  output logic        frame_last_o
);
  import ysr_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  ysr_state_e       state_q, state_d;
  logic [SRC_W-1:0] src_w_q, src_h_q;
  logic [POS_W-1:0] disp_x_q, disp_y_q, disp_w_q, disp_h_q, surf_w_q, surf_h_q;
  logic [POS_W-1:0] render_col_q, render_col_d, render_row_q, render_row_d;
  logic [POS_W-1:0] pos_col_q, pos_row_q;
  logic [SCR_W-1:0] pix_x_q, pix_y_q;
  logic             on_q, last_q;

  logic             cfg_accept, in_accept, render_go;
  ysr_mode_e        mode;
  ysr_cfg_idx_e     cfg_idx;
  logic [POS_W-1:0] cur_col, cur_row;
  logic [SCR_W-1:0] sx, sy;
  logic             col_end, row_end, on, last;

  logic             div_start, div_x_busy, div_y_busy, rd_en, out_load, out_free;
  logic [SRC_W-1:0] quo_x, quo_y, lim_x, lim_y, min_x, min_y;
  logic [XW-1:0]    src_x;
  logic [YW-1:0]    src_y;
  ysr_wr_req_t      wr_req;
  ysr_conv_ctl_t    conv_ctl;
  logic [7:0]       luma, blue_c, red_c, conv_r, conv_g, conv_b;

  logic             out_valid_q, out_valid_d;
  logic [SCR_W-1:0] out_x_q, out_y_q;
  logic [7:0]       out_r_q, out_g_q, out_b_q;
  logic             out_pv_q, out_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign cfg_idx     = ysr_cfg_idx_e'(cfg_index_i);
  assign in_accept   = in_valid_i && in_ready_o;
  assign mode        = ysr_mode_e'(mode_i);
  assign render_go   = in_accept && (mode == MODE_RENDER) &&
                       (disp_w_q != '0) && (disp_h_q != '0);
  assign out_free    = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RST_SRC_W;
      src_h_q  <= RST_SRC_H;
      disp_x_q <= '0;
      disp_y_q <= '0;
      disp_w_q <= '0;
      disp_h_q <= '0;
      surf_w_q <= RST_SURF_W;
      surf_h_q <= RST_SURF_H;
    end else if (cfg_accept) begin
      unique case (cfg_idx)
        CFG_SRC_W:  src_w_q  <= cfg_data_i[SRC_W-1:0];
        CFG_SRC_H:  src_h_q  <= cfg_data_i[SRC_W-1:0];
        CFG_DISP_X: disp_x_q <= cfg_data_i;
        CFG_DISP_Y: disp_y_q <= cfg_data_i;
        CFG_DISP_W: disp_w_q <= cfg_data_i;
        CFG_DISP_H: disp_h_q <= cfg_data_i;
        CFG_SURF_W: surf_w_q <= cfg_data_i;
        CFG_SURF_H: surf_h_q <= cfg_data_i;
      endcase
    end
  end

  // Render position: restart out-of-rectangle positions, then advance in raster order
  assign cur_col = (render_col_q >= disp_w_q) ? '0 : render_col_q;
  assign cur_row = (render_row_q >= disp_h_q) ? '0 : render_row_q;
  assign sx      = SCR_W'(disp_x_q) + SCR_W'(cur_col);
  assign sy      = SCR_W'(disp_y_q) + SCR_W'(cur_row);
  assign col_end = cur_col == disp_w_q - POS_W'(1);
  assign row_end = cur_row == disp_h_q - POS_W'(1);
  assign last    = col_end && row_end;
  assign on      = (sx < SCR_W'(surf_w_q)) && (sy < SCR_W'(surf_h_q));

  always_comb begin
    render_col_d = render_col_q;
    render_row_d = render_row_q;
    if (render_go) begin
      if (col_end) begin
        render_col_d = '0;
        render_row_d = row_end ? '0 : cur_row + POS_W'(1);
      end else begin
        render_col_d = cur_col + POS_W'(1);
        render_row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      render_col_q <= '0;
      render_row_q <= '0;
    end else begin
      render_col_q <= render_col_d;
      render_row_q <= render_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_go) begin
      pos_col_q <= cur_col;
      pos_row_q <= cur_row;
      pix_x_q   <= sx;
      pix_y_q   <= sy;
      on_q      <= on;
      last_q    <= last;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (render_go) begin
          priority if (on) begin
            state_d = ST_PRODUCT;
          end else if (last) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PRODUCT: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (!div_x_busy && !div_y_busy) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: state_d = ST_MULT;
      ST_MULT: state_d = ST_SUM;
      ST_SUM:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = state_q == ST_IDLE;
    div_start       = state_q == ST_PRODUCT;
    rd_en           = state_q == ST_ADDR;
    conv_ctl.stage1 = state_q == ST_MULT;
    conv_ctl.stage2 = state_q == ST_SUM;
    out_load        = (state_q == ST_EMIT) && out_free;
  end

  // Source mapping
  ysr_divider u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(pos_col_q) * PROD_W'(src_w_q)),
    .divisor_i  (disp_w_q),
    .busy_o     (div_x_busy),
    .quotient_o (quo_x)
  );

  ysr_divider u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(pos_row_q) * PROD_W'(src_h_q)),
    .divisor_i  (disp_h_q),
    .busy_o     (div_y_busy),
    .quotient_o (quo_y)
  );

  assign lim_x = (src_w_q == '0) ? '0 : src_w_q - SRC_W'(1);
  assign lim_y = (src_h_q == '0) ? '0 : src_h_q - SRC_W'(1);
  assign min_x = (quo_x > lim_x) ? lim_x : quo_x;
  assign min_y = (quo_y > lim_y) ? lim_y : quo_y;
  assign src_x = (32'(min_x) >= MAX_WIDTH) ? XW'(MAX_WIDTH - 1) : XW'(min_x);
  assign src_y = (32'(min_y) >= MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1) : YW'(min_y);

  // Plane memories
  assign wr_req.luma_en = in_accept && (mode == MODE_LUMA);
  assign wr_req.blue_en = in_accept && (mode == MODE_BLUE);
  assign wr_req.red_en  = in_accept && (mode == MODE_RED);
  assign wr_req.row     = sample_row_i;
  assign wr_req.col     = sample_col_i;
  assign wr_req.sample  = sample_i;

  ysr_frame_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i    (clk_i),
    .wr_req_i (wr_req),
    .rd_en_i  (rd_en),
    .rd_col_i (src_x),
    .rd_row_i (src_y),
    .luma_o   (luma),
    .blue_o   (blue_c),
    .red_o    (red_c)
  );

  ysr_color_conv u_conv (
    .clk_i   (clk_i),
    .ctl_i   (conv_ctl),
    .luma_i  (luma),
    .blue_i  (blue_c),
    .red_i   (red_c),
    .red_o   (conv_r),
    .green_o (conv_g),
    .blue_o  (conv_b)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= pix_x_q;
      out_y_q    <= pix_y_q;
      out_r_q    <= on_q ? conv_r : 8'd0;
      out_g_q    <= on_q ? conv_g : 8'd0;
      out_b_q    <= on_q ? conv_b : 8'd0;
      out_pv_q   <= on_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_x_o    = out_x_q;
  assign screen_y_o    = out_y_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign pixel_valid_o = out_pv_q;
  assign frame_last_o  = out_last_q;

  `ASSERT_DIS(a_div_lockstep, clk_i, rst_ni, (state_q == ST_DIVIDE) |-> (div_x_busy == div_y_busy), "dividers out of step")
  `ASSERT_NEVER(a_clip_not_last, clk_i, rst_ni, out_valid_o && !pixel_valid_o && !frame_last_o, "clipped result without frame end")
  `ASSERT_DIS(a_clip_black, clk_i, rst_ni, (out_valid_o && !pixel_valid_o) |-> ((red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0)), "clipped result carries color")

endmodule

// ----- tb/ysr_pixel_checker.sv -----
`timescale 1ns / 1ps
// Pixel checker for the 4:2:0 scaler: mirrors the frame stores, predicts each pixel, compares.
module ysr_pixel_checker
  import ysr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  sample_i,
  input  logic [8:0]  sample_row_i,
  input  logic [8:0]  sample_col_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [12:0] screen_x_i,
  input  logic [12:0] screen_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        pixel_valid_i,
  input  logic        frame_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned LUMA_W = DEF_MAX_WIDTH;
  localparam int unsigned LUMA_H = DEF_MAX_HEIGHT;
  localparam int unsigned CHR_W  = (LUMA_W + 1) / 2;
  localparam int unsigned CHR_H  = (LUMA_H + 1) / 2;

  typedef struct packed {
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        pixel_valid;
    logic        frame_last;
  } pixel_t;

  logic [7:0] luma_mem [LUMA_W*LUMA_H];
  logic [7:0] blue_mem [CHR_W*CHR_H];
  logic [7:0] red_mem  [CHR_W*CHR_H];

  logic [SRC_W-1:0] src_w, src_h;
  logic [POS_W-1:0] dsp_x, dsp_y, dsp_w, dsp_h, surf_w, surf_h;
  logic [POS_W-1:0] col_pos, row_pos;

  pixel_t expected_pixels [$];
  int     fails;
  int     checked;

  function automatic int unsigned scale_pos(int unsigned pos, int unsigned src,
                                            int unsigned span, int unsigned cap);
    int unsigned lim;
    int unsigned s;
    lim = (src < cap) ? src : cap;
    if (lim == 0) lim = 1;
    s = (pos * src) / span;
    if (s > lim - 1) s = lim - 1;
    return s;
  endfunction

  function automatic logic [7:0] sat8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic string fmt(pixel_t p);
    return $sformatf("x=%0d y=%0d r=%0d g=%0d b=%0d valid=%0b last=%0b", p.screen_x,
                     p.screen_y, p.red, p.green, p.blue, p.pixel_valid, p.frame_last);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [11:0] data);
    case (ysr_cfg_idx_e'(idx))
      CFG_SRC_W:  src_w  = data[SRC_W-1:0];
      CFG_SRC_H:  src_h  = data[SRC_W-1:0];
      CFG_DISP_X: dsp_x  = data;
      CFG_DISP_Y: dsp_y  = data;
      CFG_DISP_W: dsp_w  = data;
      CFG_DISP_H: dsp_h  = data;
      CFG_SURF_W: surf_w = data;
      CFG_SURF_H: surf_h = data;
    endcase
  endtask

  task automatic apply_item(logic [1:0] mode, logic [7:0] smp, logic [8:0] row,
                            logic [8:0] col);
    pixel_t      px;
    int unsigned srcx, srcy, ci;
    int          y, d, e;
    logic        at_end, visible;
    case (ysr_mode_e'(mode))
      MODE_LUMA: begin
        if (row < LUMA_H && col < LUMA_W) luma_mem[row*LUMA_W + col] = smp;
      end
      MODE_BLUE: begin
        if (row < CHR_H && col < CHR_W) blue_mem[row*CHR_W + col] = smp;
      end
      MODE_RED: begin
        if (row < CHR_H && col < CHR_W) red_mem[row*CHR_W + col] = smp;
      end
      MODE_RENDER: begin
        if (dsp_w == 0 || dsp_h == 0) return;
        if (col_pos >= dsp_w) col_pos = '0;
        if (row_pos >= dsp_h) row_pos = '0;
        px = '0;
        px.screen_x = 13'(dsp_x) + 13'(col_pos);
        px.screen_y = 13'(dsp_y) + 13'(row_pos);
        at_end  = (col_pos + 1 == dsp_w) && (row_pos + 1 == dsp_h);
        visible = (px.screen_x < surf_w) && (px.screen_y < surf_h);
        px.pixel_valid = visible;
        px.frame_last  = at_end;
        if (visible) begin
          srcx = scale_pos(col_pos, src_w, dsp_w, LUMA_W);
          srcy = scale_pos(row_pos, src_h, dsp_h, LUMA_H);
          ci = (srcy / 2) * CHR_W + srcx / 2;
          y = int'(luma_mem[srcy*LUMA_W + srcx]);
          d = int'(blue_mem[ci]) - 128;
          e = int'(red_mem[ci]) - 128;
          px.red   = sat8(y + ((359 * e + 128) >>> 8));
          px.green = sat8(y - ((88 * d + 183 * e + 128) >>> 8));
          px.blue  = sat8(y + ((454 * d + 128) >>> 8));
        end
        if (visible || at_end) expected_pixels.push_back(px);
        col_pos = col_pos + 1'b1;
        if (col_pos >= dsp_w) begin
          col_pos = '0;
          row_pos = row_pos + 1'b1;
          if (row_pos >= dsp_h) row_pos = '0;
        end
      end
    endcase
  endtask

  task automatic check_pixel();
    pixel_t got, want;
    got = {screen_x_i, screen_y_i, red_i, green_i, blue_i, pixel_valid_i, frame_last_i};
    if (expected_pixels.size() == 0) begin
      if (fails < 10) $display("ERROR: unexpected pixel %s", fmt(got));
      fails++;
    end else begin
      want = expected_pixels.pop_front();
      checked++;
      if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
          got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.pixel_valid !== want.pixel_valid || got.frame_last !== want.frame_last) begin
        if (fails < 10) begin
          $display("ERROR: pixel %0d mismatch", checked);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w   = RST_SRC_W;
      src_h   = RST_SRC_H;
      dsp_x   = '0;
      dsp_y   = '0;
      dsp_w   = '0;
      dsp_h   = '0;
      surf_w  = RST_SURF_W;
      surf_h  = RST_SURF_H;
      col_pos = '0;
      row_pos = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) apply_item(mode_i, sample_i, sample_row_i, sample_col_i);
      if (out_valid_i && out_ready_i) check_pixel();
    end
    pending_o    <= expected_pixels.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

// ----- tb/yuv420_scale_to_rgb_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the 4:2:0 scaler: clock, reset, stimulus, flow control and verdict.
module yuv420_scale_to_rgb_unit_tb;
  import ysr_pkg::*;

  localparam int unsigned LUMA_W = DEF_MAX_WIDTH;
  localparam int unsigned LUMA_H = DEF_MAX_HEIGHT;
  localparam int unsigned CHR_W  = (LUMA_W + 1) / 2;
  localparam int unsigned CHR_H  = (LUMA_H + 1) / 2;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_WAIT   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int TARGET_ITEMS = 520;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [7:0]  sample_i;
  logic [8:0]  sample_row_i;
  logic [8:0]  sample_col_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [12:0] screen_x_o;
  logic [12:0] screen_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        pixel_valid_o;
  logic        frame_last_o;

  int fail_count;
  int pending;
  int checked;

  int cycles = 0;
  int items = 0;
  int renders = 0;
  int loads = 0;
  int setups = 0;
  int burst_left = 0;
  int hold_req = 0;

  int unsigned cur_src_w = RST_SRC_W;
  int unsigned cur_src_h = RST_SRC_H;
  int unsigned cur_dsp_x = 0;
  int unsigned cur_dsp_y = 0;
  int unsigned cur_dsp_w = 0;
  int unsigned cur_dsp_h = 0;
  int unsigned cur_surf_w = RST_SURF_W;
  int unsigned cur_surf_h = RST_SURF_H;
  int unsigned col_at = 0;
  int unsigned row_at = 0;

  bit luma_done [LUMA_W*LUMA_H];
  bit blue_done [CHR_W*CHR_H];
  bit red_done  [CHR_W*CHR_H];

  yuv420_scale_to_rgb_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .sample_row_i (sample_row_i),
    .sample_col_i (sample_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .pixel_valid_o(pixel_valid_o),
    .frame_last_o (frame_last_o)
  );

  ysr_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .sample_row_i (sample_row_i),
    .sample_col_i (sample_col_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .screen_x_i   (screen_x_o),
    .screen_y_i   (screen_y_o),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .pixel_valid_i(pixel_valid_o),
    .frame_last_i (frame_last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : rx_stall
    int pat;
    int pat_left;
    int hold_left;
    int served;
    int tick;
    logic rdy;
    pat = 0;
    pat_left = 0;
    hold_left = 0;
    served = 0;
    tick = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req != served) begin
        served = hold_req;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ((tick % 7) < 4);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  function automatic int unsigned src_pos(int unsigned pos, int unsigned src,
                                          int unsigned span, int unsigned cap);
    int unsigned lim;
    int unsigned s;
    lim = (src < cap) ? src : cap;
    if (lim == 0) lim = 1;
    s = (pos * src) / span;
    if (s > lim - 1) s = lim - 1;
    return s;
  endfunction

  task automatic send(ysr_mode_e mode, logic [7:0] smp, logic [8:0] row, logic [8:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    sample_i     <= smp;
    sample_row_i <= row;
    sample_col_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items++;
    if (mode == MODE_RENDER) renders++;
    else loads++;
  endtask

  task automatic put_load(ysr_mode_e mode, int unsigned row, int unsigned col, logic [7:0] smp);
    send(mode, smp, 9'(row), 9'(col));
    case (mode)
      MODE_LUMA: if (row < LUMA_H && col < LUMA_W) luma_done[row*LUMA_W + col] = 1'b1;
      MODE_BLUE: if (row < CHR_H && col < CHR_W) blue_done[row*CHR_W + col] = 1'b1;
      MODE_RED:  if (row < CHR_H && col < CHR_W) red_done[row*CHR_W + col] = 1'b1;
      default: ;
    endcase
  endtask

  // Load whatever the next pixel reads and has not been written yet, then render it.
  task automatic render_tick();
    int unsigned cx, cy;
    if (cur_dsp_w != 0 && cur_dsp_h != 0) begin
      if (col_at >= cur_dsp_w) col_at = 0;
      if (row_at >= cur_dsp_h) row_at = 0;
      if (cur_dsp_x + col_at < cur_surf_w && cur_dsp_y + row_at < cur_surf_h) begin
        cx = src_pos(col_at, cur_src_w, cur_dsp_w, LUMA_W);
        cy = src_pos(row_at, cur_src_h, cur_dsp_h, LUMA_H);
        if (!luma_done[cy*LUMA_W + cx]) put_load(MODE_LUMA, cy, cx, 8'($urandom));
        if (!blue_done[(cy/2)*CHR_W + cx/2]) put_load(MODE_BLUE, cy/2, cx/2, 8'($urandom));
        if (!red_done[(cy/2)*CHR_W + cx/2]) put_load(MODE_RED, cy/2, cx/2, 8'($urandom));
      end
      col_at++;
      if (col_at >= cur_dsp_w) begin
        col_at = 0;
        row_at++;
        if (row_at >= cur_dsp_h) row_at = 0;
      end
    end
    send(MODE_RENDER, 8'($urandom), 9'($urandom), 9'($urandom));
  endtask

  task automatic noise_load();
    ysr_mode_e m;
    int unsigned lim;
    m = ysr_mode_e'($urandom_range(MODE_LUMA, MODE_RED));
    lim = ($urandom_range(0, 1) != 0) ? 511 : 15;
    put_load(m, $urandom_range(0, lim), $urandom_range(0, lim), 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_reg(ysr_cfg_idx_e idx, logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SRC_W:  cur_src_w  = data[SRC_W-1:0];
      CFG_SRC_H:  cur_src_h  = data[SRC_W-1:0];
      CFG_DISP_X: cur_dsp_x  = data;
      CFG_DISP_Y: cur_dsp_y  = data;
      CFG_DISP_W: cur_dsp_w  = data;
      CFG_DISP_H: cur_dsp_h  = data;
      CFG_SURF_W: cur_surf_w = data;
      CFG_SURF_H: cur_surf_h = data;
    endcase
  endtask

  task automatic apply_setup(logic [11:0] vals [8], logic [7:0] which);
    for (int i = 0; i < 8; i++) begin
      if (which[i]) set_reg(ysr_cfg_idx_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  function automatic logic [11:0] pick_value(ysr_cfg_idx_e idx);
    int r;
    logic [SRC_W-1:0] v;
    r = $urandom_range(0, 9);
    case (idx)
      CFG_SRC_W, CFG_SRC_H: begin
        v = (r == 0) ? 10'd0 : (r == 1) ? 10'h3FF : (r == 2) ? 10'd512 :
            (r == 3) ? 10'($urandom_range(513, 1023)) : 10'($urandom_range(1, 24));
        return {2'($urandom), v};
      end
      CFG_DISP_X, CFG_DISP_Y:
        return (r == 0) ? 12'd4095 : (r == 1) ? 12'($urandom_range(780, 800)) :
               12'($urandom_range(0, 20));
      CFG_DISP_W, CFG_DISP_H:
        return (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : (r == 2) ?
               12'($urandom_range(13, 300)) : 12'($urandom_range(1, 12));
      default:
        return (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : (r == 2) ?
               12'($urandom_range(1, 30)) : 12'($urandom_range(200, 4095));
    endcase
  endfunction

  initial begin
    logic [11:0] vals [8];
    logic [7:0]  which;
    logic [7:0]  luma_row [4];
    int          phase;
    int          phase_len;
    int          errors;

    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_LUMA;
    sample_i     <= '0;
    sample_row_i <= '0;
    sample_col_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty display rectangle, plane corners, loads outside the chroma planes
    render_tick();
    put_load(MODE_LUMA, LUMA_H - 1, LUMA_W - 1, 8'hFF);
    put_load(MODE_BLUE, CHR_H - 1, CHR_W - 1, 8'h00);
    put_load(MODE_RED, CHR_H - 1, CHR_W - 1, 8'hFF);
    put_load(MODE_BLUE, CHR_H, 0, 8'hAA);
    put_load(MODE_RED, 511, 511, 8'h55);
    drain();

    // 4x1 frame with saturation in both directions on every channel
    vals = '{12'd4, 12'd1, 12'd0, 12'd0, 12'd4, 12'd1, RST_SURF_W, RST_SURF_H};
    apply_setup(vals, 8'h33);
    luma_row = '{8'd255, 8'd0, 8'd255, 8'd0};
    for (int c = 0; c < 4; c++) put_load(MODE_LUMA, 0, c, luma_row[c]);
    put_load(MODE_BLUE, 0, 0, 8'hFF);
    put_load(MODE_RED, 0, 0, 8'hFF);
    put_load(MODE_BLUE, 0, 1, 8'h00);
    put_load(MODE_RED, 0, 1, 8'h00);
    repeat (7) render_tick();
    drain();

    // shrink the rectangle under the current position, clip the last pixel
    vals = '{12'd4, 12'd1, 12'd798, 12'd0, 12'd2, 12'd1, 12'd799, RST_SURF_H};
    apply_setup(vals, 8'h74);
    repeat (2) render_tick();
    drain();

    phase = 0;
    while (items < TARGET_ITEMS) begin
      case (phase)
        0: begin
          foreach (vals[i]) vals[i] = pick_value(ysr_cfg_idx_e'(i));
          which = 8'hFF;
        end
        1: begin
          vals = '{12'hFFF, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd1, 12'd4095, 12'd4095};
          which = 8'hFF;
        end
        2: begin
          vals = '{12'd16, 12'd16, 12'd0, 12'd0, 12'd8, 12'd8, RST_SURF_W, RST_SURF_H};
          which = 8'hFF;
        end
        3: begin
          vals = '{12'hA00, 12'd512, 12'd4095, 12'd4095, 12'd3, 12'd2, 12'd0, 12'd0};
          which = 8'hFF;
        end
        default: begin
          foreach (vals[i]) vals[i] = pick_value(ysr_cfg_idx_e'(i));
          which = 8'($urandom);
          if (which == 8'h00) which = 8'h04;
        end
      endcase
      apply_setup(vals, which);
      if (phase == 2) hold_req++;
      phase_len = (phase == 2) ? 60 : $urandom_range(15, 45);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) == 0) noise_load();
        else render_tick();
      end
      drain();
      phase++;
    end

    drain();
    errors = fail_count + pending;
    $display("Covered %0d transfers: %0d renders, %0d loads, %0d register setups",
             items, renders, loads, setups);
    $display("Compared %0d pixels, %0d failures, %0d cycles", checked, errors, cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
